>>> hdl/lrs_pkg.sv
// Package for the log record scanner: types, constants and the CRC-32 byte update.
package lrs_pkg;

	localparam int OFFSET_WIDTH = 40;
	localparam int RES_DEPTH    = 4;

	typedef enum logic [2:0] {
		PH_CRC   = 3'd0,
		PH_TYPE  = 3'd1,
		PH_KLEN  = 3'd2,
		PH_KEY   = 3'd3,
		PH_VLEN  = 3'd4,
		PH_VALUE = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		KIND_KEY        = 3'd0,
		KIND_VALUE      = 3'd1,
		KIND_RECORD_END = 3'd2,
		KIND_CORRUPT    = 3'd3,
		KIND_TRUNCATED  = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
		logic       new_scan;
	} in_item_t;

	typedef struct packed {
		kind_t                   kind;
		logic [7:0]              payload_byte;
		logic [7:0]              record_type;
		logic [31:0]             key_length;
		logic [31:0]             value_length;
		logic [OFFSET_WIDTH-1:0] rec_offset;
		logic                    crc_good;
		logic                    scan_done;
		logic                    last;
	} out_item_t;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> hdl/log_record_scanner_with_crc_core.sv
// Log record scanner: splits a byte stream into records and checks each record's CRC-32.
//
// Input channel in_valid/in_ready/in_data carries one file byte per transaction, with
// end_of_file and new_scan flags. Output channel out_valid/out_ready/out_data carries
// result transactions: key and value bytes as they arrive, then a record end (good CRC),
// corrupt or truncated result. One byte gives at most two results; last marks the final
// one of a byte. cfg_wr_en/cfg_wr_data write the scan base offset, loaded on new_scan.
//
// An accepted byte is held in the input register, parsed in a single pass, and its
// results are pushed into a four-entry result queue when that register advances;
// out_valid is taken from the queue count. Throughput is one byte per cycle while
// bytes give one result each and the queue has room; a byte that gives two results
// needs two output transactions, so the output port sets the sustained rate. The
// input register advances only while the queue has room for two results, so a
// stalled receiver backs up into in_ready after the queue fills. Reset clears parse
// state, the queue and the base offset; CRC state is all ones.
module log_record_scanner_with_crc_core
	import lrs_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [OFFSET_WIDTH-1:0] cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  in_item_t                in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output out_item_t               out_data
);

	localparam int PTR_W = $clog2(RES_DEPTH);
	localparam int CNT_W = $clog2(RES_DEPTH + 1);

	logic [OFFSET_WIDTH-1:0] base_ofs_q;

	logic     valid_s1;
	in_item_t item_s1;
	logic     adv_s1;

	phase_t                  phase_q;
	logic [31:0]             count_q, key_q, val_q, exp_q, crc_q;
	logic [7:0]              type_q;
	logic [OFFSET_WIDTH-1:0] start_q, pos_q;
	logic                    halted_q;

	phase_t                  e_phase, u_phase, n_phase;
	logic [31:0]             e_count, e_key, e_val, e_exp, e_crc;
	logic [31:0]             u_count, u_key, u_val, u_exp, u_crc;
	logic [31:0]             n_count, n_key, n_val, n_exp, n_crc;
	logic [7:0]              e_type, u_type, n_type;
	logic [OFFSET_WIDTH-1:0] e_start, e_pos, u_start, u_pos, n_start, n_pos;
	logic                    e_halted, n_halted;
	logic [31:0]             crc_upd, cnt_inc, byte_sh;
	logic                    data_res, rec_end, end_valid, crc_ok, good_end;
	kind_t                   data_kind, end_kind;

	out_item_t res_data, res_end, push_a;
	logic [1:0] push_n;

	out_item_t          mem_q [RES_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pop;

	assign adv_s1   = valid_s1 && (cnt_q <= CNT_W'(RES_DEPTH - 2));
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_ofs_q <= '0;
		end else if (cfg_wr_en) begin
			base_ofs_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// field parse for the byte in the input register
	always_comb begin : update
		e_phase  = phase_q;
		e_count  = count_q;
		e_key    = key_q;
		e_val    = val_q;
		e_exp    = exp_q;
		e_crc    = crc_q;
		e_type   = type_q;
		e_start  = start_q;
		e_pos    = pos_q;
		e_halted = halted_q;
		if (item_s1.new_scan) begin
			e_phase  = PH_CRC;
			e_count  = '0;
			e_key    = '0;
			e_val    = '0;
			e_exp    = '0;
			e_crc    = '1;
			e_type   = '0;
			e_pos    = base_ofs_q;
			e_start  = base_ofs_q;
			e_halted = 1'b0;
		end
		u_phase   = e_phase;
		u_count   = e_count;
		u_key     = e_key;
		u_val     = e_val;
		u_exp     = e_exp;
		u_crc     = e_crc;
		u_type    = e_type;
		u_start   = e_start;
		u_pos     = e_pos;
		crc_upd   = crc32_byte(e_crc, item_s1.data_byte);
		cnt_inc   = e_count + 32'd1;
		byte_sh   = {24'd0, item_s1.data_byte} << {e_count[1:0], 3'b000};
		data_res  = 1'b0;
		data_kind = KIND_KEY;
		rec_end   = 1'b0;
		if (!e_halted) begin
			u_pos = e_pos + OFFSET_WIDTH'(1);
			unique case (e_phase)
				PH_TYPE: begin
					u_crc   = crc_upd;
					u_type  = item_s1.data_byte;
					u_phase = PH_KLEN;
					u_count = '0;
				end
				PH_KLEN: begin
					u_crc   = crc_upd;
					u_key   = e_key | byte_sh;
					u_count = cnt_inc;
					if (cnt_inc >= 32'd4) begin
						u_count = '0;
						u_phase = (u_key != '0) ? PH_KEY : PH_VLEN;
					end
				end
				PH_KEY: begin
					u_crc     = crc_upd;
					data_res  = 1'b1;
					data_kind = KIND_KEY;
					u_count   = cnt_inc;
					if (cnt_inc == e_key) begin
						u_count = '0;
						u_phase = PH_VLEN;
					end
				end
				PH_VLEN: begin
					u_crc   = crc_upd;
					u_val   = e_val | byte_sh;
					u_count = cnt_inc;
					if (cnt_inc >= 32'd4) begin
						u_count = '0;
						if (u_val != '0) begin
							u_phase = PH_VALUE;
						end else begin
							rec_end = 1'b1;
						end
					end
				end
				PH_VALUE: begin
					u_crc     = crc_upd;
					data_res  = 1'b1;
					data_kind = KIND_VALUE;
					u_count   = cnt_inc;
					if (cnt_inc == e_val) begin
						rec_end = 1'b1;
					end
				end
				PH_CRC: begin
					if (e_count == '0) begin
						u_start = e_pos;
					end
					u_exp   = e_exp | byte_sh;
					u_count = cnt_inc;
					if (cnt_inc >= 32'd4) begin
						u_count = '0;
						u_phase = PH_TYPE;
					end
				end
				default: begin
					u_phase = PH_CRC;
				end
			endcase
		end
		crc_ok    = (~u_crc == u_exp);
		good_end  = rec_end && crc_ok;
		end_valid = !e_halted && (rec_end || item_s1.end_of_file);
		if (rec_end) begin
			end_kind = crc_ok ? KIND_RECORD_END : KIND_CORRUPT;
		end else begin
			end_kind = KIND_TRUNCATED;
		end
	end

	always_comb begin : next_state
		n_phase  = u_phase;
		n_count  = u_count;
		n_key    = u_key;
		n_val    = u_val;
		n_exp    = u_exp;
		n_crc    = u_crc;
		n_type   = u_type;
		n_start  = u_start;
		n_pos    = u_pos;
		n_halted = e_halted;
		if (good_end) begin
			n_phase = PH_CRC;
			n_count = '0;
			n_key   = '0;
			n_val   = '0;
			n_exp   = '0;
			n_crc   = '1;
			n_type  = '0;
		end
		if (end_valid && !(good_end && !item_s1.end_of_file)) begin
			n_halted = 1'b1;
		end
	end

	always_comb begin : results
		res_data              = '0;
		res_data.kind         = data_kind;
		res_data.payload_byte = item_s1.data_byte;
		res_data.record_type  = u_type;
		res_data.last         = !end_valid;

		res_end               = '0;
		res_end.kind          = end_kind;
		res_end.record_type   = u_type;
		res_end.key_length    = u_key;
		res_end.value_length  = u_val;
		res_end.rec_offset    = u_start;
		res_end.crc_good      = good_end;
		res_end.scan_done     = good_end && item_s1.end_of_file;
		res_end.last          = 1'b1;

		push_a = data_res ? res_data : res_end;
		if (!adv_s1) begin
			push_n = 2'd0;
		end else begin
			push_n = 2'({1'b0, data_res} + {1'b0, end_valid});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_CRC;
			count_q  <= '0;
			key_q    <= '0;
			val_q    <= '0;
			exp_q    <= '0;
			crc_q    <= '1;
			type_q   <= '0;
			start_q  <= '0;
			pos_q    <= '0;
			halted_q <= 1'b0;
		end else if (adv_s1) begin
			phase_q  <= n_phase;
			count_q  <= n_count;
			key_q    <= n_key;
			val_q    <= n_val;
			exp_q    <= n_exp;
			crc_q    <= n_crc;
			type_q   <= n_type;
			start_q  <= n_start;
			pos_q    <= n_pos;
			halted_q <= n_halted;
		end
	end

	// result queue
	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_a;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= res_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_W'(RES_DEPTH))
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && halted_q && !item_s1.new_scan |-> push_n == 2'd0)
		else $error("results produced while halted");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && end_valid && !good_end |=> halted_q)
		else $error("scan not halted after corrupt or truncated record");

endmodule

>>> tb/sv/tb.sv
// Testbench for the log record scanner: random record files checked against a byte-level predictor.
`timescale 1ns / 1ps

module tb;
	import lrs_pkg::*;

	localparam int                      RUN_LIMIT  = 400000;
	localparam int                      DRAIN_GAP  = 8;
	localparam int                      PHASE_ITEMS = 210;
	localparam logic [OFFSET_WIDTH-1:0] OFS_MAX    = {OFFSET_WIDTH{1'b1}};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [OFFSET_WIDTH-1:0] cfg_wr_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	in_item_t                in_data = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	out_item_t               out_data;

	int unsigned cycle_count = 0;
	int          send_idle = 0;
	int          recv_idle = 0;
	int          bytes_sent = 0;
	int          cfg_sel = 0;
	logic [7:0]  file_q[$];

	log_record_scanner_with_crc_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	// CRC-32 (IEEE), LSB first, one byte
	function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ 32'hEDB88320;
			end
		end
		return c;
	endfunction

	class log_scan_tracker;
		logic [OFFSET_WIDTH-1:0] start_ofs;
		phase_t                  phase;
		logic [31:0]             fcount;
		logic [31:0]             ksize;
		logic [31:0]             vsize;
		logic [31:0]             crc_expect;
		logic [31:0]             crc;
		logic [7:0]              typ;
		logic [OFFSET_WIDTH-1:0] rec_start;
		logic [OFFSET_WIDTH-1:0] fpos;
		bit                      halted;
		out_item_t               due[$];
		int                      errors;
		int                      checked;
		int                      records;

		function new();
			start_ofs = '0;
			clear_record();
			rec_start = '0;
			fpos = '0;
			halted = 1'b0;
			errors = 0;
			checked = 0;
			records = 0;
		endfunction

		function void clear_record();
			phase = PH_CRC;
			fcount = '0;
			ksize = '0;
			vsize = '0;
			crc_expect = '0;
			crc = 32'hFFFFFFFF;
			typ = '0;
		endfunction

		function out_item_t result_of(kind_t k, logic [7:0] p, bit full, bit good, bit done);
			out_item_t r;
			r.kind = k;
			r.payload_byte = p;
			r.record_type = typ;
			r.key_length = full ? ksize : 32'd0;
			r.value_length = full ? vsize : 32'd0;
			r.rec_offset = full ? rec_start : '0;
			r.crc_good = good;
			r.scan_done = done;
			r.last = 1'b0;
			return r;
		endfunction

		function void take_byte(in_item_t it);
			out_item_t               res[$];
			logic [OFFSET_WIDTH-1:0] pos;
			logic [7:0]              b;
			bit                      rec_end;
			b = it.data_byte;
			rec_end = 1'b0;
			if (it.new_scan) begin
				clear_record();
				fpos = start_ofs;
				rec_start = fpos;
				halted = 1'b0;
			end
			if (halted) begin
				return;
			end
			pos = fpos;
			fpos = pos + OFFSET_WIDTH'(1);
			case (phase)
				PH_TYPE: begin
					crc = crc_next(crc, b);
					typ = b;
					phase = PH_KLEN;
					fcount = '0;
				end
				PH_KLEN: begin
					crc = crc_next(crc, b);
					ksize = ksize | (32'(b) << (8 * fcount[1:0]));
					fcount = fcount + 32'd1;
					if (fcount >= 32'd4) begin
						fcount = '0;
						phase = (ksize != 32'd0) ? PH_KEY : PH_VLEN;
					end
				end
				PH_KEY: begin
					crc = crc_next(crc, b);
					res = {res, result_of(KIND_KEY, b, 1'b0, 1'b0, 1'b0)};
					fcount = fcount + 32'd1;
					if (fcount == ksize) begin
						fcount = '0;
						phase = PH_VLEN;
					end
				end
				PH_VLEN: begin
					crc = crc_next(crc, b);
					vsize = vsize | (32'(b) << (8 * fcount[1:0]));
					fcount = fcount + 32'd1;
					if (fcount >= 32'd4) begin
						fcount = '0;
						if (vsize != 32'd0) begin
							phase = PH_VALUE;
						end else begin
							rec_end = 1'b1;
						end
					end
				end
				PH_VALUE: begin
					crc = crc_next(crc, b);
					res = {res, result_of(KIND_VALUE, b, 1'b0, 1'b0, 1'b0)};
					fcount = fcount + 32'd1;
					if (fcount == vsize) begin
						rec_end = 1'b1;
					end
				end
				default: begin
					if (fcount == 32'd0) begin
						rec_start = pos;
					end
					crc_expect = crc_expect | (32'(b) << (8 * fcount[1:0]));
					fcount = fcount + 32'd1;
					if (fcount >= 32'd4) begin
						fcount = '0;
						phase = PH_TYPE;
					end
				end
			endcase
			if (rec_end) begin
				if (~crc == crc_expect) begin
					res = {res, result_of(KIND_RECORD_END, 8'd0, 1'b1, 1'b1, it.end_of_file)};
					records++;
					clear_record();
					if (it.end_of_file) begin
						halted = 1'b1;
					end
				end else begin
					res = {res, result_of(KIND_CORRUPT, 8'd0, 1'b1, 1'b0, 1'b0)};
					halted = 1'b1;
				end
			end else if (it.end_of_file) begin
				res = {res, result_of(KIND_TRUNCATED, 8'd0, 1'b1, 1'b0, 1'b0)};
				halted = 1'b1;
			end
			if (res.size() > 0) begin
				res[res.size() - 1].last = 1'b1;
			end
			foreach (res[i]) begin
				due = {due, res[i]};
			end
		endfunction

		function void cmp(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		function void match_result(out_item_t got);
			out_item_t want;
			if (due.size() == 0) begin
				$error("result transaction with none pending: kind %0d", got.kind);
				errors++;
				return;
			end
			want = due.pop_front();
			checked++;
			cmp("kind", 64'(want.kind), 64'(got.kind));
			cmp("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
			cmp("record_type", 64'(want.record_type), 64'(got.record_type));
			cmp("key_length", 64'(want.key_length), 64'(got.key_length));
			cmp("value_length", 64'(want.value_length), 64'(got.value_length));
			cmp("rec_offset", 64'(want.rec_offset), 64'(got.rec_offset));
			cmp("crc_good", 64'(want.crc_good), 64'(got.crc_good));
			cmp("scan_done", 64'(want.scan_done), 64'(got.scan_done));
			cmp("last", 64'(want.last), 64'(got.last));
		endfunction
	endclass

	log_scan_tracker tracker = new();

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			tracker.match_result(out_data);
		end
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_byte(input logic [7:0] d, input bit eof, input bit ns);
		in_item_t it;
		it.data_byte = d;
		it.end_of_file = eof;
		it.new_scan = ns;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		tracker.take_byte(it);
		bytes_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.due.size() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_offset(input logic [OFFSET_WIDTH-1:0] v);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.start_ofs = v;
	endtask

	task automatic append_record(input logic [7:0] typ, input logic [31:0] klen,
			input logic [31:0] vlen, input bit corrupt);
		logic [7:0]  body[$];
		logic [31:0] c;
		body = {body, typ};
		for (int i = 0; i < 4; i++) body = {body, klen[8*i +: 8]};
		for (int i = 0; i < int'(klen); i++) body = {body, 8'($urandom_range(255))};
		for (int i = 0; i < 4; i++) body = {body, vlen[8*i +: 8]};
		for (int i = 0; i < int'(vlen); i++) body = {body, 8'($urandom_range(255))};
		c = 32'hFFFFFFFF;
		foreach (body[i]) c = crc_next(c, body[i]);
		c = ~c;
		if (corrupt) begin
			c = c ^ (32'd1 << $urandom_range(31));
		end
		for (int i = 0; i < 4; i++) file_q = {file_q, c[8*i +: 8]};
		foreach (body[i]) file_q = {file_q, body[i]};
	endtask

	// header with a huge length, cut short by end of file
	task automatic append_open(input bit in_value);
		logic [31:0] len;
		int          k;
		len = $urandom;
		for (int i = 0; i < 5; i++) file_q = {file_q, 8'($urandom_range(255))};
		if (in_value) begin
			k = $urandom_range(1, 3);
			for (int i = 0; i < 4; i++) file_q = {file_q, 8'(k >> (8 * i))};
			for (int i = 0; i < k; i++) file_q = {file_q, 8'($urandom_range(255))};
		end
		for (int i = 0; i < 4; i++) file_q = {file_q, len[8*i +: 8]};
		for (int i = 0; i < $urandom_range(0, 5); i++) file_q = {file_q, 8'($urandom_range(255))};
	endtask

	task automatic send_file(input int eof_at);
		foreach (file_q[i]) send_byte(file_q[i], i == eof_at, i == 0);
	endtask

	function automatic logic [31:0] pick_len();
		int r;
		r = $urandom_range(19);
		if (r < 6) return 32'd0;
		if (r == 19) return 32'($urandom_range(7, 40));
		return 32'($urandom_range(1, 6));
	endfunction

	task automatic random_file();
		int style;
		int n;
		int cut;
		file_q.delete();
		n = $urandom_range(1, 4);
		for (int r = 0; r < n; r++) begin
			append_record(8'($urandom_range(255)), pick_len(), pick_len(), $urandom_range(99) < 12);
		end
		style = $urandom_range(99);
		if (style < 60) begin
			send_file(file_q.size() - 1);
		end else if (style < 75) begin
			cut = $urandom_range(1, file_q.size() - 1);
			while (file_q.size() > cut) void'(file_q.pop_back());
			send_file(cut - 1);
		end else if (style < 85) begin
			append_open($urandom_range(1));
			send_file(file_q.size() - 1);
		end else if (style < 93) begin
			// no end of file: the next new scan cuts in
			cut = $urandom_range(1, file_q.size());
			while (file_q.size() > cut) void'(file_q.pop_back());
			send_file(-1);
		end else begin
			n = file_q.size() - 1;
			for (int i = 0; i < $urandom_range(1, 3); i++) file_q = {file_q, 8'($urandom_range(255))};
			send_file(n);
		end
	endtask

	task automatic noise_burst();
		for (int i = 0; i < $urandom_range(4, 16); i++) begin
			send_byte(8'($urandom_range(255)), $urandom_range(99) < 10, $urandom_range(99) < 8);
		end
	endtask

	function automatic logic [OFFSET_WIDTH-1:0] pick_offset();
		logic [63:0] r;
		r = {$urandom, $urandom};
		cfg_sel++;
		case (cfg_sel % 4)
			0: begin
				return '0;
			end
			1: begin
				return OFS_MAX;
			end
			2: begin
				return OFS_MAX - OFFSET_WIDTH'($urandom_range(0, 20));
			end
			default: begin
				return r[OFFSET_WIDTH-1:0];
			end
		endcase
	endfunction

	initial begin
		int target;
		int files;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 19;
		recv_idle = 87;

		// good record at the top offset, wrapping past it, ends the file cleanly
		write_offset(OFS_MAX);
		file_q.delete();
		append_record(8'hFF, 32'd1, 32'd1, 1'b0);
		send_file(file_q.size() - 1);
		// one-byte file, then bytes while halted
		send_byte(8'h00, 1'b1, 1'b1);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h00, 1'b1, 1'b0);
		// end of file in the key length field
		file_q.delete();
		append_record(8'h5A, 32'd3, 32'd0, 1'b0);
		while (file_q.size() > 7) void'(file_q.pop_back());
		send_file(6);

		files = 0;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 19;
					recv_idle = 87;
				end
				1: begin
					send_idle = 87;
					recv_idle = 19;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			target = bytes_sent + PHASE_ITEMS;
			while (bytes_sent < target) begin
				if (files % 3 == 0) begin
					write_offset(pick_offset());
				end
				if ($urandom_range(9) == 0) begin
					noise_burst();
				end else begin
					random_file();
				end
				files++;
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("tb: %0d bytes in %0d files, %0d results checked, %0d good records",
			bytes_sent, files, tracker.checked, tracker.records);
		$display("tb: offsets from zero to the top of the range, three handshake pacing modes");
		if (tracker.errors == 0 && tracker.due.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
